### rtl/core/hpf_pkg.sv
// shared types, packet type codes and preamble tables for the hci packet framer
package hpf_pkg;

   // hci packet type codes
   localparam logic [2:0] HCI_TYPE_CMD = 3'd1;
   localparam logic [2:0] HCI_TYPE_ACL = 3'd2;
   localparam logic [2:0] HCI_TYPE_SCO = 3'd3;
   localparam logic [2:0] HCI_TYPE_EVT = 3'd4;
   localparam logic [2:0] HCI_TYPE_ISO = 3'd5;

   // preamble sizes per type
   localparam logic [2:0] CMD_HDR_BYTES = 3'd3;
   localparam logic [2:0] ACL_HDR_BYTES = 3'd4;
   localparam logic [2:0] SCO_HDR_BYTES = 3'd3;
   localparam logic [2:0] EVT_HDR_BYTES = 3'd2;
   localparam logic [2:0] ISO_HDR_BYTES = 3'd4;

   // byte offset of the length field inside the preamble
   localparam logic [2:0] CMD_LEN_POS = 3'd2;
   localparam logic [2:0] ACL_LEN_POS = 3'd2;
   localparam logic [2:0] SCO_LEN_POS = 3'd2;
   localparam logic [2:0] EVT_LEN_POS = 3'd1;
   localparam logic [2:0] ISO_LEN_POS = 3'd2;

   // default cap on the preamble size
   localparam int MAX_PREAMBLE_BYTES_DEF = 4;

   // framing phase, one-hot
   typedef enum logic [1:0] {
      PHASE_PREAMBLE = 2'b01,
      PHASE_PAYLOAD  = 2'b10
   } phase_type;

   // per-byte framing flags
   typedef struct packed {
      logic start_of_packet;
      logic in_preamble;
      logic end_of_packet;
   } frame_flags_type;

   // preamble size for a type, zero for unknown types
   function automatic logic [2:0] preamble_size(input logic [2:0] ptype);
      logic [2:0] size;
      case (ptype)
         HCI_TYPE_CMD: size = CMD_HDR_BYTES;
         HCI_TYPE_ACL: size = ACL_HDR_BYTES;
         HCI_TYPE_SCO: size = SCO_HDR_BYTES;
         HCI_TYPE_EVT: size = EVT_HDR_BYTES;
         HCI_TYPE_ISO: size = ISO_HDR_BYTES;
         default:      size = 3'd0;
      endcase
      return size;
   endfunction

   // length field offset for a type
   function automatic logic [2:0] length_offset(input logic [2:0] ptype);
      logic [2:0] off;
      case (ptype)
         HCI_TYPE_CMD: off = CMD_LEN_POS;
         HCI_TYPE_ACL: off = ACL_LEN_POS;
         HCI_TYPE_SCO: off = SCO_LEN_POS;
         HCI_TYPE_EVT: off = EVT_LEN_POS;
         HCI_TYPE_ISO: off = ISO_LEN_POS;
         default:      off = 3'd0;
      endcase
      return off;
   endfunction

endpackage

### rtl/core/hpf_frame_ctl.sv
// framing state: preamble counter, length capture and payload countdown
module hpf_frame_ctl #(
   parameter int MAX_PREAMBLE_BYTES = hpf_pkg::MAX_PREAMBLE_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [2:0]               packet_type,
   input  logic [7:0]               data_byte,
   output hpf_pkg::frame_flags_type flags
);

   localparam logic [2:0] MaxPre = 3'(MAX_PREAMBLE_BYTES);

   hpf_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         index_ff, index_in;
   logic [2:0]         type_ff, type_in;
   logic [7:0]         low_ff, low_in;
   logic [15:0]        left_ff, left_in;

   logic [2:0]  type_eff;
   logic [2:0]  raw_size;
   logic [2:0]  psize;
   logic [2:0]  off;
   logic [7:0]  low_new;
   logic [15:0] left_dec;
   logic [15:0] len;
   logic        last_pre;
   logic        len_hi_here;

   // per-transaction table lookups and arithmetic
   always_comb begin
      type_eff    = (index_ff == 3'd0) ? packet_type : type_ff;
      raw_size    = hpf_pkg::preamble_size(type_eff);
      psize       = (raw_size > MaxPre) ? MaxPre : raw_size;
      off         = hpf_pkg::length_offset(type_eff);
      low_new     = (index_ff == off) ? data_byte
                                      : ((index_ff == 3'd0) ? 8'd0 : low_ff);
      last_pre    = ({1'b0, index_ff} + 4'd1) >= {1'b0, psize};
      len_hi_here = ({1'b0, off} + 4'd1) == {1'b0, index_ff};
      left_dec    = left_ff - 16'd1;
      if (type_eff == hpf_pkg::HCI_TYPE_ACL && len_hi_here) begin
         len = {data_byte, low_new};
      end else if (type_eff == hpf_pkg::HCI_TYPE_ISO && len_hi_here) begin
         len = {2'b00, data_byte[5:0], low_new};
      end else begin
         len = {8'd0, low_new};
      end
   end

   // next state and flags
   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      type_in  = type_ff;
      low_in   = low_ff;
      left_in  = left_ff;
      flags    = '0;
      case (phase_ff)
         hpf_pkg::PHASE_PAYLOAD: begin
            left_in = left_dec;
            if (left_dec == 16'd0) begin
               flags.end_of_packet = 1'b1;
               phase_in            = hpf_pkg::PHASE_PREAMBLE;
            end
         end
         hpf_pkg::PHASE_PREAMBLE: begin
            flags.in_preamble     = 1'b1;
            flags.start_of_packet = (index_ff == 3'd0);
            if (index_ff == 3'd0) begin
               low_in = 8'd0;
            end
            if (psize == 3'd0) begin
               // unknown type makes a one-byte packet
               flags.end_of_packet = 1'b1;
               index_in            = 3'd0;
               type_in             = 3'd0;
            end else begin
               type_in = type_eff;
               low_in  = low_new;
               if (last_pre) begin
                  index_in = 3'd0;
                  if (len == 16'd0) begin
                     flags.end_of_packet = 1'b1;
                  end else begin
                     left_in  = len;
                     phase_in = hpf_pkg::PHASE_PAYLOAD;
                  end
               end else begin
                  index_in = index_ff + 3'd1;
               end
            end
         end
         default: begin
            phase_in = hpf_pkg::PHASE_PREAMBLE;
         end
      endcase
   end

   // state registers, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hpf_pkg::PHASE_PREAMBLE;
         index_ff <= 3'd0;
         type_ff  <= 3'd0;
         low_ff   <= 8'd0;
         left_ff  <= 16'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         type_ff  <= type_in;
         low_ff   <= low_in;
         left_ff  <= left_in;
      end
   end

endmodule

### rtl/core/hci_packet_framer.sv
// hci packet framer top level: input handshake, framing state and result register
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_stall  packet_type[2:0], data_byte[7:0]
//  rsp_     out        rsp_valid/rsp_stall  out_byte[7:0], start_of_packet,
//                                           in_preamble, end_of_packet
//
// one transaction per cycle while req_stall is low; each result appears in the cycle after its byte is taken.
// the framing state updates on the accepting edge and the result lands in one register.
// req_stall is high only while a held result is stalled, so a new byte is taken in the
// same cycle that the held result leaves. reset clears the framing state and empties
// the result register.
module hci_packet_framer #(
   parameter int MAX_PREAMBLE_BYTES = hpf_pkg::MAX_PREAMBLE_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_packet_type,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_start_of_packet,
   output logic       rsp_in_preamble,
   output logic       rsp_end_of_packet
);

   logic                     accept;
   hpf_pkg::frame_flags_type flags;
   hpf_pkg::frame_flags_type flags_ff;
   logic [7:0]               byte_ff;
   logic                     valid_ff, valid_in;

   // input handshake
   assign req_stall = valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   hpf_frame_ctl #(
      .MAX_PREAMBLE_BYTES(MAX_PREAMBLE_BYTES)
   ) u_frame_ctl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .packet_type(req_packet_type),
      .data_byte  (req_data_byte),
      .flags      (flags)
   );

   // result register occupancy
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= req_data_byte;
         flags_ff <= flags;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_start_of_packet = flags_ff.start_of_packet;
   assign rsp_in_preamble     = flags_ff.in_preamble;
   assign rsp_end_of_packet   = flags_ff.end_of_packet;

endmodule

### tb/hci_packet_framer_test.sv
// self-checking testbench for the hci packet framer
`timescale 1ns / 1ps

module hci_packet_framer_test;

   localparam int MAX_PRE = hpf_pkg::MAX_PREAMBLE_BYTES_DEF;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_BYTES = 720;

   // type codes with no defined preamble
   localparam logic [2:0] HCI_TYPE_NONE  = 3'd0;
   localparam logic [2:0] HCI_TYPE_RSVD6 = 3'd6;
   localparam logic [2:0] HCI_TYPE_RSVD7 = 3'd7;

   typedef struct packed {
      logic [7:0] data;
      logic       sop;
      logic       pre;
      logic       eop;
   } framed_byte_type;

   typedef struct packed {
      logic [2:0]      ptype;
      logic [7:0]      data;
      logic            pinned;
      framed_byte_type want;
   } directed_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_packet_type;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_start_of_packet;
   logic       rsp_in_preamble;
   logic       rsp_end_of_packet;

   // framing state of the predictor
   logic        fr_in_payload;
   logic [2:0]  fr_index;
   logic [2:0]  fr_type;
   logic [7:0]  fr_len_low;
   logic [15:0] fr_left;

   framed_byte_type  pending_frames[$];
   framed_byte_type  predicted;
   framed_byte_type  oldest;
   framed_byte_type  pin_value;
   logic             pin_on;
   logic             no_idle;
   directed_row_type directed_rows [DIRECTED_COUNT];
   int               mismatch_count;
   int               sent_count;
   int               received_count;
   int               packet_count;

   hci_packet_framer #(
      .MAX_PREAMBLE_BYTES(MAX_PRE)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_packet_type     (req_packet_type),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_start_of_packet (rsp_start_of_packet),
      .rsp_in_preamble     (rsp_in_preamble),
      .rsp_end_of_packet   (rsp_end_of_packet)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard limit on the run
   initial begin
      #25_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // frames one byte and advances the predicted framing state
   function automatic framed_byte_type frame_byte(input logic [2:0] ptype,
                                                  input logic [7:0] data);
      framed_byte_type r;
      logic [2:0]      psize;
      logic [2:0]      off;
      logic [15:0]     len;
      r = '{data: data, sop: 1'b0, pre: 1'b0, eop: 1'b0};
      if (fr_in_payload) begin
         fr_left = fr_left - 16'd1;
         if (fr_left == 16'd0) begin
            r.eop = 1'b1;
            fr_in_payload = 1'b0;
         end
      end else begin
         r.pre = 1'b1;
         // type is sampled on the first preamble byte only
         if (fr_index == 3'd0) begin
            r.sop = 1'b1;
            fr_type = ptype;
            fr_len_low = 8'd0;
         end
         case (fr_type)
            hpf_pkg::HCI_TYPE_CMD: begin
               psize = hpf_pkg::CMD_HDR_BYTES;
               off = hpf_pkg::CMD_LEN_POS;
            end
            hpf_pkg::HCI_TYPE_ACL: begin
               psize = hpf_pkg::ACL_HDR_BYTES;
               off = hpf_pkg::ACL_LEN_POS;
            end
            hpf_pkg::HCI_TYPE_SCO: begin
               psize = hpf_pkg::SCO_HDR_BYTES;
               off = hpf_pkg::SCO_LEN_POS;
            end
            hpf_pkg::HCI_TYPE_EVT: begin
               psize = hpf_pkg::EVT_HDR_BYTES;
               off = hpf_pkg::EVT_LEN_POS;
            end
            hpf_pkg::HCI_TYPE_ISO: begin
               psize = hpf_pkg::ISO_HDR_BYTES;
               off = hpf_pkg::ISO_LEN_POS;
            end
            default: begin
               psize = 3'd0;
               off = 3'd0;
            end
         endcase
         if (int'(psize) > MAX_PRE) psize = 3'(MAX_PRE);
         if (psize == 3'd0) begin
            // unknown type makes a single byte packet
            r.eop = 1'b1;
            fr_index = 3'd0;
            fr_type = HCI_TYPE_NONE;
         end else begin
            if (fr_index == off) fr_len_low = data;
            if (int'(fr_index) + 1 >= int'(psize)) begin
               len = {8'd0, fr_len_low};
               if (fr_type == hpf_pkg::HCI_TYPE_ACL && int'(off) + 1 == int'(fr_index))
                  len = {data, fr_len_low};
               else if (fr_type == hpf_pkg::HCI_TYPE_ISO && int'(off) + 1 == int'(fr_index))
                  len = {2'b00, data[5:0], fr_len_low};
               fr_index = 3'd0;
               if (len == 16'd0) begin
                  r.eop = 1'b1;
               end else begin
                  fr_left = len;
                  fr_in_payload = 1'b1;
               end
            end else begin
               fr_index = fr_index + 3'd1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at %0t ns: %s got %0h, want %0h", $time, what, got, want);
   endtask

   // draws the wait before one transaction
   function automatic int pick_wait();
      return no_idle ? 0 : $urandom_range(17);
   endfunction

   // predicts on every accepted byte and checks every accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predicted = frame_byte(req_packet_type, req_data_byte);
            if (pin_on) predicted = pin_value;
            pending_frames.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            received_count++;
            if (rsp_end_of_packet) packet_count++;
            if (pending_frames.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_out_byte, 0);
            end else begin
               oldest = pending_frames.pop_front();
               if (rsp_out_byte !== oldest.data)
                  report_mismatch("out_byte", rsp_out_byte, oldest.data);
               if (rsp_start_of_packet !== oldest.sop)
                  report_mismatch("start_of_packet", rsp_start_of_packet, oldest.sop);
               if (rsp_in_preamble !== oldest.pre)
                  report_mismatch("in_preamble", rsp_in_preamble, oldest.pre);
               if (rsp_end_of_packet !== oldest.eop)
                  report_mismatch("end_of_packet", rsp_end_of_packet, oldest.eop);
            end
         end
      end
   end

   // result side: random stall before each transaction
   initial begin
      int hold;
      wait (reset === 1'b0);
      forever begin
         hold = pick_wait();
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // drives one byte after a random gap and waits until it is taken
   task automatic send_byte(input logic [2:0] ptype, input logic [7:0] data,
                            input logic pinned, input framed_byte_type want);
      int gap;
      gap = pick_wait();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      pin_on = pinned;
      pin_value = want;
      req_valid <= 1'b1;
      req_packet_type <= ptype;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // holds off the sender until every pending result has come back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(negedge clock);
   endtask

   // sends one well-formed packet with random content around the length field
   task automatic send_packet(input logic [2:0] ptype, input logic [15:0] len);
      logic [7:0] hdr [4];
      int         hdr_len;
      for (int i = 0; i < 4; i++) hdr[i] = 8'($urandom_range(255));
      case (ptype)
         hpf_pkg::HCI_TYPE_CMD, hpf_pkg::HCI_TYPE_SCO: begin
            hdr_len = 3;
            hdr[2] = len[7:0];
         end
         hpf_pkg::HCI_TYPE_EVT: begin
            hdr_len = 2;
            hdr[1] = len[7:0];
         end
         hpf_pkg::HCI_TYPE_ACL: begin
            hdr_len = 4;
            hdr[2] = len[7:0];
            hdr[3] = len[15:8];
         end
         hpf_pkg::HCI_TYPE_ISO: begin
            // the top two bits of the length field are noise
            hdr_len = 4;
            hdr[2] = len[7:0];
            hdr[3] = {hdr[3][7:6], len[13:8]};
         end
         default: hdr_len = 1;
      endcase
      send_byte(ptype, hdr[0], 1'b0, '0);
      for (int i = 1; i < hdr_len; i++)
         send_byte(3'($urandom_range(7)), hdr[i], 1'b0, '0);
      if (hdr_len > 1)
         for (int j = 0; j < int'(len); j++)
            send_byte(3'($urandom_range(7)), 8'($urandom_range(255)), 1'b0, '0);
   endtask

   // stimulus
   initial begin
      logic [2:0]  ptype;
      logic [15:0] len;
      bit          paused;
      int          guard;
      reset = 1'b1;
      req_valid = 1'b0;
      req_packet_type = HCI_TYPE_NONE;
      req_data_byte = 8'd0;
      rsp_stall = 1'b0;
      pin_on = 1'b0;
      pin_value = '0;
      no_idle = 1'b0;
      paused = 1'b0;
      mismatch_count = 0;
      sent_count = 0;
      received_count = 0;
      packet_count = 0;
      fr_in_payload = 1'b0;
      fr_index = 3'd0;
      fr_type = HCI_TYPE_NONE;
      fr_len_low = 8'd0;
      fr_left = 16'd0;

      directed_rows = '{
         // command with zero length, first byte after reset
         '{hpf_pkg::HCI_TYPE_CMD, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_CMD, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_CMD, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
         // event of two payload bytes, type changes mid-packet are ignored
         '{hpf_pkg::HCI_TYPE_EVT, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
         '{HCI_TYPE_RSVD6,        8'h02, 1'b1, '{8'h02, 1'b0, 1'b1, 1'b0}},
         '{HCI_TYPE_NONE,         8'h80, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0}},
         '{HCI_TYPE_RSVD7,        8'h7F, 1'b1, '{8'h7F, 1'b0, 1'b0, 1'b1}},
         // unknown types give one byte packets
         '{HCI_TYPE_NONE,         8'h55, 1'b1, '{8'h55, 1'b1, 1'b1, 1'b1}},
         '{HCI_TYPE_RSVD6,        8'hAA, 1'b1, '{8'hAA, 1'b1, 1'b1, 1'b1}},
         '{HCI_TYPE_RSVD7,        8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
         // acl with a little-endian length of one
         '{hpf_pkg::HCI_TYPE_ACL, 8'h01, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_SCO, 8'h20, 1'b1, '{8'h20, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_ISO, 8'h01, 1'b1, '{8'h01, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_CMD, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_EVT, 8'hC3, 1'b0, '0},
         // iso drops the top two length bits, so this length is zero
         '{hpf_pkg::HCI_TYPE_ISO, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_ISO, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_ISO, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_ISO, 8'hC0, 1'b1, '{8'hC0, 1'b0, 1'b1, 1'b1}},
         // sco with one payload byte
         '{hpf_pkg::HCI_TYPE_SCO, 8'h12, 1'b1, '{8'h12, 1'b1, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_SCO, 8'h34, 1'b0, '0},
         '{hpf_pkg::HCI_TYPE_SCO, 8'h01, 1'b0, '0},
         '{hpf_pkg::HCI_TYPE_SCO, 8'h00, 1'b0, '0},
         // event with zero length
         '{hpf_pkg::HCI_TYPE_EVT, 8'h0E, 1'b1, '{8'h0E, 1'b1, 1'b1, 1'b0}},
         '{hpf_pkg::HCI_TYPE_EVT, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_byte(directed_rows[i].ptype, directed_rows[i].data,
                   directed_rows[i].pinned, directed_rows[i].want);
      drain_results();

      // random packets, mostly short, with idle-free stretches
      while (sent_count < DIRECTED_COUNT + RANDOM_BYTES) begin
         if (!paused && sent_count >= DIRECTED_COUNT + RANDOM_BYTES / 2) begin
            drain_results();
            paused = 1'b1;
         end
         no_idle = ($urandom_range(4) == 0);
         if ($urandom_range(11) == 0) begin
            case ($urandom_range(2))
               0:       ptype = HCI_TYPE_NONE;
               1:       ptype = HCI_TYPE_RSVD6;
               default: ptype = HCI_TYPE_RSVD7;
            endcase
            len = 16'd0;
         end else begin
            ptype = 3'($urandom_range(hpf_pkg::HCI_TYPE_ISO, hpf_pkg::HCI_TYPE_CMD));
            if ($urandom_range(5) == 0)
               len = 16'd0;
            else if ($urandom_range(7) == 0)
               len = 16'($urandom_range(40, 9));
            else
               len = 16'($urandom_range(8, 1));
            // a few acl and iso packets carry a high length byte
            if ((ptype == hpf_pkg::HCI_TYPE_ACL || ptype == hpf_pkg::HCI_TYPE_ISO) &&
                $urandom_range(39) == 0)
               len = 16'($urandom_range(300, 256));
         end
         send_packet(ptype, len);
      end

      // wait for the last results, then a few more cycles
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (pending_frames.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
      if (pending_frames.size() != 0)
         report_mismatch("results never returned", pending_frames.size(), 0);

      $display("framed %0d bytes into %0d packets, all five types plus unknown codes,",
               received_count, packet_count);
      $display("zero, short and two-byte lengths, under random and no stalls");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
